@@ design/multiply_xor_fold_hash32_core_defines.svh @@
// assertion macros for the multiply-xor-fold hash core checker
// no dependencies; taken in by the checker file only
`ifndef MULTIPLY_XOR_FOLD_HASH32_CORE_DEFINES_SVH
`define MULTIPLY_XOR_FOLD_HASH32_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define MXF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MXF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// checks the cycle after reset is sampled low
`define MXF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mxf_pkg.sv @@
// shared types, constants and the fold function of the multiply-xor-fold hash
// no dependencies
package mxf_pkg;

  localparam logic [31:0] FoldMult  = 32'hC2B0C3CC;
  localparam logic [31:0] HashStart = 32'd1;
  localparam logic [1:0]  LaneFirst = 2'd0;
  localparam logic [1:0]  LaneLast  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [1:0]  lane;
  } hstate_t;

  // 32x32 product folded back to 32 bits
  function automatic logic [31:0] fold_mix(input logic [31:0] h);
    logic [63:0] prod;
    prod = {32'b0, h} * {32'b0, FoldMult};
    return prod[31:0] ^ prod[63:32];
  endfunction

endpackage

@@ design/mxf_step.sv @@
// hash update for one registered request: lane xor, optional group close
// depends on mxf_pkg
module mxf_step (
  input  mxf_pkg::item_t   item,
  input  mxf_pkg::hstate_t cur,
  output mxf_pkg::hstate_t nxt,
  output logic [31:0]      result
);
  import mxf_pkg::*;

  logic [4:0]  lane_sh;
  logic [31:0] mixed;
  logic [1:0]  lane_after;
  logic        close;
  logic [31:0] closed;
  logic [31:0] hash_done;

  always_comb begin
    lane_sh = {cur.lane, 3'b000};
    if (item.no_data) begin
      mixed      = cur.hash;
      lane_after = cur.lane;
    end else begin
      mixed      = cur.hash ^ ({24'b0, item.data_byte} << lane_sh);
      lane_after = (cur.lane == LaneLast) ? LaneFirst : cur.lane + 2'd1;
    end
    // a full group closes here; a partial one only at the end of the message
    close     = (!item.no_data && (cur.lane == LaneLast)) ||
                (item.last && (lane_after != LaneFirst));
    closed    = fold_mix(mixed);
    hash_done = close ? closed : mixed;
    result    = hash_done;
    if (item.last) begin
      nxt.hash = HashStart;
      nxt.lane = LaneFirst;
    end else begin
      nxt.hash = hash_done;
      nxt.lane = lane_after;
    end
  end

endmodule

@@ design/mxf_out_reg.sv @@
// result register with valid/stall handshake
// no package dependencies
module mxf_out_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] load_data,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] out_hash_value,
  output logic        blocked
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] data_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign blocked        = valid_r && out_stall;
  assign out_valid      = valid_r;
  assign out_hash_value = data_r;

endmodule

@@ design/multiply_xor_fold_hash32_core.sv @@
// Byte-serial 32-bit multiply-xor-fold hash. One byte request is taken every
// cycle while in_stall is low; the final request of a message passes the input
// register, then the hash update into the result register. The hash update
// holds one 32x32 constant multiply, which sets the clock path. Requests that
// do not end a message keep flowing while a result waits; the input stalls
// only when a final request meets a result that is still held by out_stall.
// depends on mxf_pkg, mxf_step, mxf_out_reg
module multiply_xor_fold_hash32_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_no_data,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import mxf_pkg::*;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  hstate_t st_r;
  hstate_t st_nxt;
  logic    [31:0] step_result;
  logic    out_blocked;
  logic    s1_hold;
  logic    s1_go;
  logic    accept;

  assign s1_hold  = s1_item_r.last && out_blocked;
  assign s1_go    = s1_valid_r && !s1_hold;
  assign in_stall = s1_valid_r && s1_hold;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      st_r.hash  <= HashStart;
      st_r.lane  <= LaneFirst;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.no_data   <= in_no_data;
      s1_item_r.last      <= in_last;
    end
  end

  mxf_step u_step (
    .item   (s1_item_r),
    .cur    (st_r),
    .nxt    (st_nxt),
    .result (step_result)
  );

  mxf_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_go && s1_item_r.last),
    .load_data      (step_result),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .blocked        (out_blocked)
  );

endmodule

@@ design/mxf_checker.sv @@
// port-level checks for the multiply-xor-fold hash core, bound to the top
// depends on multiply_xor_fold_hash32_core_defines.svh
`include "multiply_xor_fold_hash32_core_defines.svh"

module mxf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_no_data,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value
);

  // input back-pressure only comes from a held result
  `MXF_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall, "in_stall without held result")

  // a stalled request keeps its payload
  `MXF_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable({in_data_byte, in_no_data, in_last}), "held request changed")

  `MXF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hash_value), "held result changed")

  `MXF_ASSERT_RST(a_rst_empty, !out_valid, "result valid after reset")

endmodule

bind multiply_xor_fold_hash32_core mxf_checker u_mxf_checker (.*);
